### rtl/esdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// esdc_pkg
// Shared types and constants for the edge stream degree classifier.
// ---------------------------------------------------------------------------
package esdc_pkg;

   localparam int IdW         = 10;
   localparam int DegW        = 10;
   localparam int CountW      = 10;
   localparam int EdgeW       = 16;
   localparam int HistDepth   = 1 << DegW;
   localparam int MaxVerticesDefault = 1024;

   localparam logic [DegW-1:0]   DegMax    = {DegW{1'b1}};
   localparam logic [EdgeW-1:0]  EdgeMax   = {EdgeW{1'b1}};
   localparam logic [DegW-1:0]   CycleDeg  = DegW'(2);
   localparam logic [DegW-1:0]   WheelDeg  = DegW'(3);
   localparam logic [CountW-1:0] WheelMinN = CountW'(4);
   localparam logic [CountW-1:0] PathOdd   = CountW'(2);

   localparam int ReqDataW = 24;
   localparam int RspDataW = 48;

   typedef enum logic [1:0] {
      EULER_CIRCUIT = 2'd0,
      EULER_PATH    = 2'd1,
      EULER_NONE    = 2'd2
   } euler_type;

   // Counters and histogram taps feeding the classifier
   typedef struct packed {
      logic [CountW-1:0] vertex_total;
      logic [EdgeW-1:0]  edge_total;
      logic [CountW-1:0] odd_vertex_total;
      logic [DegW-1:0]   hist_two;
      logic [DegW-1:0]   hist_three;
      logic [DegW-1:0]   hist_n_minus_one;
      logic              degree_saturated;
   } status_type;

   // Result word, last field in the lowest bits
   typedef struct packed {
      logic              degree_saturated;
      logic              is_wheel;
      logic              is_cycle;
      logic              is_complete;
      euler_type         euler_class;
      logic [CountW-1:0] odd_vertex_total;
      logic [EdgeW-1:0]  edge_total;
      logic [CountW-1:0] vertex_total;
   } result_type;

   localparam int ResultW = $bits(result_type);

endpackage
`default_nettype wire

### rtl/esdc_classify.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// esdc_classify
// Builds the result word from the counters and the histogram taps.
// ---------------------------------------------------------------------------
module esdc_classify
   import esdc_pkg::*;
(
   input  status_type status,
   output result_type result
);

   logic [CountW-1:0] n;
   logic [CountW-1:0] n_minus_one;

   assign n           = status.vertex_total;
   assign n_minus_one = n - CountW'(1);

   always_comb begin
      result                  = '0;
      result.vertex_total     = n;
      result.edge_total       = status.edge_total;
      result.odd_vertex_total = status.odd_vertex_total;
      result.degree_saturated = status.degree_saturated;

      if (status.odd_vertex_total == '0) begin
         result.euler_class = EULER_CIRCUIT;
      end else if (status.odd_vertex_total == PathOdd) begin
         result.euler_class = EULER_PATH;
      end else begin
         result.euler_class = EULER_NONE;
      end

      result.is_complete = (n > CountW'(1)) && (status.hist_n_minus_one == n);
      result.is_cycle    = (status.hist_two == n);

      // four vertices: the hub also has degree three
      if (n == WheelMinN) begin
         result.is_wheel = (status.hist_three == WheelMinN);
      end else if (n > WheelMinN) begin
         result.is_wheel = (status.hist_three == n_minus_one) &&
                           (status.hist_n_minus_one == DegW'(1));
      end else begin
         result.is_wheel = 1'b0;
      end
   end

endmodule
`default_nettype wire

### rtl/edge_stream_degree_classifier.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted edge reads and updates the degree, then the old and new histogram
//   bins, once per distinct end (once for a self loop, not at all for an ignored
//   edge: id zero or out of range); then bin n-1 is read and the word is emitted.
// A new edge is taken only after the last word is registered; each endpoint does a
//   read-modify-write through the degree and histogram memory ports.
// Reset: synchronous; a clearing pass then zeroes both memories with req_tready low.
// ---------------------------------------------------------------------------
// edge_stream_degree_classifier
// Per-vertex degree store and degree histogram, with Euler parity and graph
// shape flags reported after every edge.
// ---------------------------------------------------------------------------
module edge_stream_degree_classifier
   import esdc_pkg::*;
#(
   parameter int MAX_VERTICES = MaxVerticesDefault
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output      logic                req_tready,
   input  wire logic [ReqDataW-1:0] req_tdata,   // end_a[9:0], end_b[19:10]
   output      logic                rsp_tvalid,
   input  wire logic                rsp_tready,
   // vertex_total[9:0], edge_total[25:10], odd_vertex_total[35:26],
   // euler_class[37:36], is_complete[38], is_cycle[39], is_wheel[40],
   // degree_saturated[41]
   output      logic [RspDataW-1:0] rsp_tdata
);

   localparam int StoreDepth = (MAX_VERTICES < (1 << IdW)) ? MAX_VERTICES : (1 << IdW);
   localparam int StoreAw    = $clog2(StoreDepth);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_DEG,
      ST_UPD_DEG,
      ST_HIST_OLD,
      ST_HIST_NEW,
      ST_RD_N,
      ST_EMIT
   } state_type;

   // memories
   logic [DegW-1:0] deg_mem  [StoreDepth];
   logic [DegW-1:0] hist_mem [HistDepth];

   logic               deg_we;
   logic [StoreAw-1:0] deg_wa, deg_ra;
   logic [DegW-1:0]    deg_wd, deg_rd_ff;
   logic               hist_we;
   logic [DegW-1:0]    hist_wa, hist_ra, hist_wd, hist_rd_ff;

   always_ff @(posedge clock) begin
      if (deg_we) begin
         deg_mem[deg_wa] <= deg_wd;
      end
      deg_rd_ff <= deg_mem[deg_ra];
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_wa] <= hist_wd;
      end
      hist_rd_ff <= hist_mem[hist_ra];
   end

   // control and counters
   state_type         state_ff, state_in;
   logic [DegW-1:0]   clr_cnt_ff;
   logic [IdW-1:0]    end_a_ff, end_b_ff;
   logic              self_ff, second_ff;
   logic [DegW-1:0]   old_ff, nw_ff;
   logic              chg_ff;
   logic [CountW-1:0] vertex_ff, odd_ff;
   logic [EdgeW-1:0]  edge_ff;
   logic [DegW-1:0]   hist2_ff, hist3_ff;
   logic              sat_ff;
   logic              rsp_valid_ff;
   result_type        rsp_data_ff;

   logic [IdW-1:0]    req_end_a, req_end_b;
   logic              req_ok;
   logic [IdW-1:0]    cur_v;
   logic [DegW:0]     deg_sum;
   logic              sat_hit;
   logic [DegW-1:0]   deg_new;
   logic              deg_chg;
   logic              rsp_free;
   status_type        status;
   result_type        result;

   assign req_end_a = req_tdata[IdW-1:0];
   assign req_end_b = req_tdata[2*IdW-1:IdW];
   assign req_ok    = (req_end_a != '0) && (req_end_b != '0) &&
                      (32'(req_end_a) < MAX_VERTICES) && (32'(req_end_b) < MAX_VERTICES);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspDataW - ResultW){1'b0}}, rsp_data_ff};
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   assign cur_v   = second_ff ? end_b_ff : end_a_ff;
   assign deg_sum = {1'b0, deg_rd_ff} + (self_ff ? (DegW+1)'(2) : (DegW+1)'(1));
   assign sat_hit = (deg_sum >= {1'b0, DegMax});
   assign deg_new = sat_hit ? DegMax : deg_sum[DegW-1:0];
   assign deg_chg = (deg_new != deg_rd_ff);

   // memory port steering
   always_comb begin
      deg_we  = 1'b0;
      deg_wa  = cur_v[StoreAw-1:0];
      deg_wd  = deg_new;
      deg_ra  = cur_v[StoreAw-1:0];
      hist_we = 1'b0;
      hist_wa = old_ff;
      hist_wd = hist_rd_ff - DegW'(1);
      hist_ra = vertex_ff - CountW'(1);
      case (state_ff)
         ST_CLEAR: begin
            deg_we  = 1'b1;
            deg_wa  = clr_cnt_ff[StoreAw-1:0];
            deg_wd  = '0;
            hist_we = 1'b1;
            hist_wa = clr_cnt_ff;
            hist_wd = '0;
         end
         ST_UPD_DEG: begin
            deg_we  = deg_chg;
            hist_ra = deg_rd_ff;
         end
         ST_HIST_OLD: begin
            hist_we = chg_ff && (old_ff != '0);
            hist_ra = nw_ff;
         end
         ST_HIST_NEW: begin
            hist_we = chg_ff;
            hist_wa = nw_ff;
            hist_wd = hist_rd_ff + DegW'(1);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      status.vertex_total     = vertex_ff;
      status.edge_total       = edge_ff;
      status.odd_vertex_total = odd_ff;
      status.hist_two         = hist2_ff;
      status.hist_three       = hist3_ff;
      status.hist_n_minus_one = hist_rd_ff;
      status.degree_saturated = sat_ff;
   end

   esdc_classify u_classify (
      .status (status),
      .result (result)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:    if (clr_cnt_ff == DegMax) state_in = ST_IDLE;
         ST_IDLE:     if (req_tvalid) state_in = req_ok ? ST_RD_DEG : ST_RD_N;
         ST_RD_DEG:   state_in = ST_UPD_DEG;
         ST_UPD_DEG:  state_in = ST_HIST_OLD;
         ST_HIST_OLD: state_in = ST_HIST_NEW;
         ST_HIST_NEW: state_in = (self_ff || second_ff) ? ST_RD_N : ST_RD_DEG;
         ST_RD_N:     state_in = ST_EMIT;
         ST_EMIT:     if (rsp_free) state_in = ST_IDLE;
         default:     state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         second_ff    <= 1'b0;
         vertex_ff    <= '0;
         edge_ff      <= '0;
         odd_ff       <= '0;
         hist2_ff     <= '0;
         hist3_ff     <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (state_ff == ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + DegW'(1);
         end

         if (state_ff == ST_IDLE && req_tvalid) begin
            end_a_ff  <= req_end_a;
            end_b_ff  <= req_end_b;
            self_ff   <= (req_end_a == req_end_b);
            second_ff <= 1'b0;
            if (req_ok && edge_ff != EdgeMax) begin
               edge_ff <= edge_ff + EdgeW'(1);
            end
         end

         if (state_ff == ST_UPD_DEG) begin
            old_ff <= deg_rd_ff;
            nw_ff  <= deg_new;
            chg_ff <= deg_chg;
            if (sat_hit) begin
               sat_ff <= 1'b1;
            end
            if (deg_chg) begin
               if (deg_rd_ff == '0) begin
                  vertex_ff <= vertex_ff + CountW'(1);
               end
               odd_ff <= odd_ff
                         - CountW'((deg_rd_ff != '0) && deg_rd_ff[0])
                         + CountW'(deg_new[0]);
            end
         end

         if (state_ff == ST_HIST_NEW) begin
            second_ff <= 1'b1;
         end

         // shadow copies of histogram bins two and three
         if (hist_we && hist_wa == CycleDeg) begin
            hist2_ff <= hist_wd;
         end
         if (hist_we && hist_wa == WheelDeg) begin
            hist3_ff <= hist_wd;
         end

         if (state_ff == ST_EMIT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= result;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule
`default_nettype wire

### rtl/esdc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// esdc_checker
// Port-level checks for the edge stream degree classifier.
// ---------------------------------------------------------------------------
module esdc_checker
   import esdc_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_tready,
   input wire logic                rsp_tvalid,
   input wire logic                rsp_tready,
   input wire logic [RspDataW-1:0] rsp_tdata
);

   result_type rsp_word;
   assign rsp_word = result_type'(rsp_tdata[ResultW-1:0]);

   // clearing pass holds off input, and no word is pending after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("esdc: activity right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("esdc: stalled response word changed");

   // odd-degree vertices are a subset of the seen ones; clipped degrees
   // can leave the odd count itself odd
   a_odd_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_word.odd_vertex_total <= rsp_word.vertex_total))
      else $error("esdc: odd vertex count inconsistent");

   a_euler_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_word.euler_class == EULER_CIRCUIT) ==
                      (rsp_word.odd_vertex_total == '0)))
      else $error("esdc: euler class disagrees with odd count");

   a_complete_n: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_word.is_complete |-> rsp_word.vertex_total > CountW'(1))
      else $error("esdc: complete flag with fewer than two vertices");

endmodule

bind edge_stream_degree_classifier esdc_checker u_esdc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the edge stream degree classifier. Edges are sent
// on the request stream. A local degree and histogram model predicts every
// status word. The checker compares each returned word field by field, with
// random idling on both sides, a long receive hold-off, and a run that
// saturates a vertex degree.
// ---------------------------------------------------------------------------
module testbench;
   import esdc_pkg::*;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata  = '0;   // end_a[9:0], end_b[19:10]
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   // vertex_total[9:0], edge_total[25:10], odd_vertex_total[35:26],
   // euler_class[37:36], is_complete[38], is_cycle[39], is_wheel[40],
   // degree_saturated[41]
   logic [RspDataW-1:0] rsp_tdata;

   edge_stream_degree_classifier i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Graph model
   logic [DegW-1:0]   degree_of   [HistDepth];
   logic [CountW-1:0] degree_hist [HistDepth];
   logic [CountW-1:0] vertex_count = '0;
   logic [EdgeW-1:0]  edge_count   = '0;
   logic [CountW-1:0] odd_total    = '0;
   logic              saturation_seen = 1'b0;

   // expected words, ring of pending predictions
   localparam int ExpDepth = 16;
   result_type expected_status [ExpDepth];
   int exp_wr = 0;
   int exp_rd = 0;

   int send_idle_pct   = 0;
   int take_idle_pct   = 0;
   int hold_cycles_req = 0;
   int mismatch_count  = 0;

   initial begin
      for (int i = 0; i < HistDepth; i++) begin
         degree_of[i]   = '0;
         degree_hist[i] = '0;
      end
   end

   function automatic void bump_degree(int v, int amount);
      int old_deg;
      int new_deg;
      old_deg = int'(degree_of[v]);
      new_deg = old_deg + amount;
      if (new_deg >= int'(DegMax)) begin
         new_deg = int'(DegMax);
         saturation_seen = 1'b1;
      end
      if (new_deg == old_deg) return;
      if (old_deg > 0) begin
         degree_hist[old_deg]--;
         if (old_deg % 2 == 1) odd_total--;
      end else begin
         vertex_count++;
      end
      degree_hist[new_deg]++;
      if (new_deg % 2 == 1) odd_total++;
      degree_of[v] = DegW'(new_deg);
   endfunction

   // Applies one edge and queues the status word it should produce
   function automatic void predict_classification(logic [IdW-1:0] a, logic [IdW-1:0] b);
      result_type st;
      int n;
      if (a != 0 && b != 0 && int'(a) < MaxVerticesDefault
          && int'(b) < MaxVerticesDefault) begin
         if (a == b) begin
            bump_degree(a, 2);
         end else begin
            bump_degree(a, 1);
            bump_degree(b, 1);
         end
         if (edge_count != EdgeMax) edge_count++;
      end
      n = int'(vertex_count);
      st = '0;
      st.vertex_total     = vertex_count;
      st.edge_total       = edge_count;
      st.odd_vertex_total = odd_total;
      if (odd_total == 0)             st.euler_class = EULER_CIRCUIT;
      else if (odd_total == PathOdd)  st.euler_class = EULER_PATH;
      else                            st.euler_class = EULER_NONE;
      st.is_complete = (n > 1 && n - 1 < HistDepth) ? (int'(degree_hist[n-1]) == n) : 1'b0;
      st.is_cycle    = (int'(degree_hist[CycleDeg]) == n);
      if (n == int'(WheelMinN))
         st.is_wheel = (degree_hist[WheelDeg] == WheelMinN);
      else if (n > int'(WheelMinN) && n - 1 < HistDepth)
         st.is_wheel = (int'(degree_hist[WheelDeg]) == n - 1) && (degree_hist[n-1] == 1);
      st.degree_saturated = saturation_seen;
      expected_status[exp_wr % ExpDepth] = st;
      exp_wr++;
   endfunction

   task automatic report(string what, int got, int want);
      if (mismatch_count < 40)
         $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_field(string what, int got, int want);
      if (got != want) report(what, got, want);
   endtask

   // Result checker
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result_type'(rsp_tdata[ResultW-1:0]);
         if (exp_wr == exp_rd) begin
            report("unexpected word, vertex_total", int'(got.vertex_total), -1);
         end else begin
            want = expected_status[exp_rd % ExpDepth];
            exp_rd++;
            check_field("vertex_total", int'(got.vertex_total), int'(want.vertex_total));
            check_field("edge_total", int'(got.edge_total), int'(want.edge_total));
            check_field("odd_vertex_total", int'(got.odd_vertex_total),
                        int'(want.odd_vertex_total));
            check_field("euler_class", int'(got.euler_class), int'(want.euler_class));
            check_field("is_complete", int'(got.is_complete), int'(want.is_complete));
            check_field("is_cycle", int'(got.is_cycle), int'(want.is_cycle));
            check_field("is_wheel", int'(got.is_wheel), int'(want.is_wheel));
            check_field("degree_saturated", int'(got.degree_saturated),
                        int'(want.degree_saturated));
            check_field("padding", int'(rsp_tdata[RspDataW-1:ResultW]), 0);
         end
      end
   end

   // Receiver: random idling, or a counted hold-off on request
   initial begin : receiver
      int hold_len;
      forever begin
         @(negedge clock);
         if (hold_cycles_req > 0) begin
            hold_len = hold_cycles_req;
            hold_cycles_req = 0;
            rsp_tready <= 1'b0;
            repeat (hold_len - 1) begin
               @(negedge clock);
               rsp_tready <= 1'b0;
            end
         end else begin
            rsp_tready <= ($urandom_range(99) >= take_idle_pct);
         end
      end
   end

   task automatic send_edge(logic [IdW-1:0] a, logic [IdW-1:0] b);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(ReqDataW - 2*IdW){1'b0}}, b, a};
      do @(posedge clock); while (!req_tready);
      predict_classification(a, b);
   endtask

   task automatic release_input();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic test_ignored_edges();
      send_edge(0, 0);       // empty graph reads as a cycle
      send_edge(0, 1023);
      send_edge(1023, 0);
      send_edge(0, 1);
   endtask

   // Four-vertex ring, then a hub with spokes: cycle, then wheel of five
   task automatic test_graph_shapes();
      send_edge(2, 3);       // n = 2, complete
      send_edge(3, 4);
      send_edge(4, 5);
      send_edge(5, 2);       // ring
      send_edge(1, 2);
      send_edge(1, 3);
      send_edge(1, 4);
      send_edge(1, 5);       // wheel
      send_edge(3, 3);       // self loop
      send_edge(1023, 1023);
      send_edge(1, 1023);
      send_edge(1023, 1);
      send_edge(682, 341);
      send_edge(341, 682);
      send_edge(0, 682);
      send_edge(512, 0);
   endtask

   function automatic logic [IdW-1:0] random_id(int pool);
      return IdW'($urandom_range(pool, 1));
   endfunction

   task automatic test_random_edges(int count);
      int sent;
      int kind;
      logic [IdW-1:0] a;
      logic [IdW-1:0] b;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(99);
         if (kind < 5) begin
            a = IdW'($urandom_range(1023));
            b = '0;
            if ($urandom_range(1)) send_edge(a, b);
            else                   send_edge(b, a);
         end else begin
            if (kind < 15) begin
               a = random_id(40);
               b = a;
            end else if (kind < 70) begin
               a = random_id(40);
               b = random_id(40);
            end else begin
               a = random_id(1023);
               b = random_id(1023);
            end
            send_edge(a, b);
            sent++;
         end
      end
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      take_idle_pct = 0;
      hold_cycles_req = 400;
      for (int i = 0; i < 30; i++)
         send_edge(random_id(40), random_id(40));
   endtask

   // Drive one vertex to the degree ceiling by self loops, with a plain edge last from an even degree, then add more
   task automatic test_degree_saturation();
      send_idle_pct = 0;
      take_idle_pct = 0;
      while (degree_of[900] < DegMax - 1)
         send_edge(900, 900);
      if (degree_of[900] != DegMax)
         send_edge(900, 901);
      send_edge(900, 900);
      send_edge(901, 900);
   endtask

   task automatic drain_results();
      int waited;
      waited = 0;
      while (exp_wr != exp_rd && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 0;
      take_idle_pct = 0;
      test_ignored_edges();
      test_graph_shapes();

      send_idle_pct = 29;
      take_idle_pct = 63;
      test_random_edges(350);
      send_idle_pct = 63;
      take_idle_pct = 29;
      test_random_edges(350);
      send_idle_pct = 0;
      take_idle_pct = 0;
      test_random_edges(300);

      test_backpressure();
      test_degree_saturation();
      release_input();

      drain_results();
      if (exp_wr != exp_rd)
         report("missing words", 0, exp_wr - exp_rd);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
